/* sv/spvm_pkg.sv */
// Shared constants, types and the font table of the sprite machine core.
package spvm_pkg;

    // Fixed machine geometry.
    localparam int MEMORY_BYTES      = 4096;
    localparam int SCREEN_WIDTH      = 64;
    localparam int SCREEN_HEIGHT     = 32;
    localparam int DEF_STACK_DEPTH   = 16;
    localparam int DEF_PROGRAM_BASE  = 512;
    localparam int FONT_BYTES        = 80;
    localparam int MEM_AW            = $clog2(MEMORY_BYTES);
    localparam int ROW_AW            = $clog2(SCREEN_HEIGHT);
    localparam int COL_AW            = $clog2(SCREEN_WIDTH);

    // Stream widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;

    // Selected instruction words and low bytes.
    localparam logic [15:0] OP_CLS     = 16'h00E0;
    localparam logic [15:0] OP_RET     = 16'h00EE;
    localparam logic [7:0]  NN_SKP     = 8'h9E;
    localparam logic [7:0]  NN_SKNP    = 8'hA1;
    localparam logic [7:0]  NN_GETDLY  = 8'h07;
    localparam logic [7:0]  NN_WAITKEY = 8'h0A;
    localparam logic [7:0]  NN_SETDLY  = 8'h15;
    localparam logic [7:0]  NN_SETSND  = 8'h18;
    localparam logic [7:0]  NN_ADDI    = 8'h1E;
    localparam logic [7:0]  NN_FONT    = 8'h29;
    localparam logic [7:0]  NN_BCD     = 8'h33;
    localparam logic [7:0]  NN_STORE   = 8'h55;
    localparam logic [7:0]  NN_LOAD    = 8'h65;

    // Command codes carried on the input tuser.
    typedef enum logic [2:0] {
        CMD_LOAD  = 3'd0,
        CMD_EXEC  = 3'd1,
        CMD_KEY   = 3'd2,
        CMD_RDMEM = 3'd3,
        CMD_RDPIX = 3'd4
    } cmd_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_INIT, ST_IDLE, ST_WM, ST_RM, ST_RM2, ST_RP, ST_RP2,
        ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_EXEC, ST_WVF,
        ST_D0, ST_D1, ST_BCD, ST_S55A, ST_S55B, ST_S65A, ST_S65B,
        ST_TICK, ST_OUT
    } state_t;

    // Built-in hexadecimal glyphs, five rows each.
    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // Reset content of one memory byte: glyphs at the bottom, zero above.
    function automatic logic [7:0] font_at(input logic [MEM_AW-1:0] a);
        logic [7:0] v;
        v = 8'h00;
        if (a < MEM_AW'(FONT_BYTES)) begin
            v = FONT[a[6:0]];
        end
        return v;
    endfunction

endpackage

/* sv/spvm_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module spvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/sprite_vm_cpu_core.sv */
// Top level of the sprite machine core: sequencer, datapath and stores.
//
// Input items arrive on s_tvalid/s_tready with the command on s_tuser and the
// operands on s_tdata. Each item gives exactly one result item on
// m_tvalid/m_tready, held in an output register until it is taken.
// After reset the block runs a clearing pass that writes the glyph table and
// zeros into main memory; s_tready stays low meanwhile.
// The bitmap and the general registers clear at once through row and entry
// valid bits.
// An execute command first fetches the instruction word and reads VX, VY and
// V0 through the single register-file port; a sprite is then drawn row by
// row, the decimal split writes its three digits one by one, and register
// store and load move one register at a time. The one memory read port and
// the one register port make these steps serial.
// The block takes one item at a time; a new item is accepted once the
// previous result has moved into the output register. When the receiver
// stalls, the result holds and the block waits before loading the next one.
module sprite_vm_cpu_core import spvm_pkg::*; #(
    parameter int STACK_DEPTH  = DEF_STACK_DEPTH,
    parameter int PROGRAM_BASE = DEF_PROGRAM_BASE
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // address[11:0], data_byte[19:12], key_index[23:20], key_down[24],
    // random_byte[32:25], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[2:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // program_counter[11:0], fetched_opcode[27:12], read_value[35:28],
    // screen_updated[36], sound_active[37], bad_opcode[38],
    // waiting_for_key[39]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int SP_W = $clog2(STACK_DEPTH);

    // Sequencer and item registers.
    state_t              state_reg, state_next;
    logic [MEM_AW-1:0]   clr_reg;
    logic [11:0]         addr_reg;
    logic [7:0]          data_reg, rnd_reg;
    logic [7:0]          hi_reg, lo_reg, vx_reg, vy_reg, v0_reg;
    logic [4:0]          cnt_reg;
    logic                coll_reg, vf_reg;
    logic [3:0]          dig0_reg, dig1_reg, dig2_reg;
    logic [7:0]          rd_reg;
    logic                drew_reg, bad_reg, wait_reg;

    // Architectural state.
    logic [11:0]         pc_reg;
    logic [15:0]         idx_reg;
    logic [SP_W-1:0]     sp_reg;
    logic [11:0]         stack_reg [STACK_DEPTH];
    logic [7:0]          delay_reg, sound_reg;
    logic [15:0]         keys_reg;
    logic [15:0]         rf_valid_reg;
    logic [SCREEN_HEIGHT-1:0] bm_valid_reg;
    logic                rf_rv_reg, bm_rv_reg;

    // Output register.
    logic                m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // RAM ports.
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata, mem_q;
    logic                rf_we;
    logic [3:0]          rf_waddr, rf_raddr;
    logic [7:0]          rf_wdata, rf_rdata, rf_q;
    logic                bm_we;
    logic [ROW_AW-1:0]   bm_waddr, bm_raddr;
    logic [SCREEN_WIDTH-1:0] bm_wdata, bm_rdata, bm_q;

    // Decoded fields.
    logic [15:0]         op;
    logic [3:0]          op_x, op_y, op_n, op_nib;
    logic [7:0]          op_nn;
    logic [11:0]         op_nnn;
    logic                accept;

    // Execute decode results.
    logic                dec_bad, dec_wait, dec_we, dec_vf;
    logic [11:0]         dec_pc;
    logic [7:0]          dec_wd;
    state_t              dec_st;

    // Helpers.
    logic [SP_W-1:0]     sp_inc, sp_dec;
    logic [11:0]         idx_cnt;
    logic [ROW_AW-1:0]   row_cnt;
    logic [16:0]         isum;
    logic [8:0]          add9, sub_xy, sub_yx;
    logic [3:0]          key_first;
    logic                key_any;
    logic [7:0]          spr;
    logic [SCREEN_WIDTH-1:0] spr_w, mask;
    logic [1:0]          bcd_h;
    logic [6:0]          bcd_r, bcd_o;
    logic [14:0]         bcd_tp;
    logic [3:0]          bcd_t;

    assign op      = {hi_reg, lo_reg};
    assign op_nib  = hi_reg[7:4];
    assign op_x    = hi_reg[3:0];
    assign op_y    = lo_reg[7:4];
    assign op_n    = lo_reg[3:0];
    assign op_nn   = lo_reg;
    assign op_nnn  = {hi_reg[3:0], lo_reg};
    assign accept  = s_tvalid && s_tready;

    assign sp_inc  = (sp_reg == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg + SP_W'(1);
    assign sp_dec  = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - SP_W'(1);
    assign idx_cnt = idx_reg[11:0] + {7'b0, cnt_reg};
    assign row_cnt = vy_reg[ROW_AW-1:0] + cnt_reg[ROW_AW-1:0];
    assign isum    = {1'b0, idx_reg} + {9'b0, vx_reg};
    assign add9    = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign sub_xy  = {1'b0, vx_reg} - {1'b0, vy_reg};
    assign sub_yx  = {1'b0, vy_reg} - {1'b0, vx_reg};
    assign rf_q    = rf_rdata & {8{rf_rv_reg}};
    assign bm_q    = bm_rdata & {SCREEN_WIDTH{bm_rv_reg}};

    // Lowest pressed key.
    always_comb begin
        key_first = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (keys_reg[i]) begin
                key_first = 4'(i);
            end
        end
        key_any = |keys_reg;
    end

    // Sprite row placed on the bitmap row with horizontal wrap.
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            spr[c] = mem_q[7 - c];
        end
        spr_w = SCREEN_WIDTH'(spr);
        mask  = (spr_w << vx_reg[COL_AW-1:0])
              | (spr_w >> (7'(SCREEN_WIDTH) - {1'b0, vx_reg[COL_AW-1:0]}));
    end

    // Decimal split of VX by constant compares and a reciprocal multiply.
    always_comb begin
        if (vx_reg >= 8'd200) begin
            bcd_h = 2'd2;
            bcd_r = 7'(vx_reg - 8'd200);
        end else if (vx_reg >= 8'd100) begin
            bcd_h = 2'd1;
            bcd_r = 7'(vx_reg - 8'd100);
        end else begin
            bcd_h = 2'd0;
            bcd_r = vx_reg[6:0];
        end
        bcd_tp = {8'b0, bcd_r} * 15'd205;
        bcd_t  = bcd_tp[14:11];
        bcd_o  = bcd_r - 7'({3'b0, bcd_t} * 7'd10);
    end

    // Instruction decode for the execute step.
    always_comb begin
        dec_bad  = 1'b0;
        dec_wait = 1'b0;
        dec_we   = 1'b0;
        dec_vf   = 1'b0;
        dec_wd   = 8'h00;
        dec_pc   = pc_reg + 12'd2;
        dec_st   = ST_TICK;
        unique case (op_nib)
            4'h0: begin
                if (op == OP_RET) begin
                    dec_pc = stack_reg[sp_dec] + 12'd2;
                end else if (op != OP_CLS) begin
                    dec_bad = 1'b1;
                end
            end
            4'h1, 4'h2: dec_pc = op_nnn;
            4'h3: if (vx_reg == op_nn) dec_pc = pc_reg + 12'd4;
            4'h4: if (vx_reg != op_nn) dec_pc = pc_reg + 12'd4;
            4'h5: begin
                if (op_n != 4'h0) dec_bad = 1'b1;
                else if (vx_reg == vy_reg) dec_pc = pc_reg + 12'd4;
            end
            4'h6: begin
                dec_we = 1'b1;
                dec_wd = op_nn;
            end
            4'h7: begin
                dec_we = 1'b1;
                dec_wd = vx_reg + op_nn;
            end
            4'h8: begin
                dec_we = 1'b1;
                unique case (op_n)
                    4'h0: dec_wd = vy_reg;
                    4'h1: dec_wd = vx_reg | vy_reg;
                    4'h2: dec_wd = vx_reg & vy_reg;
                    4'h3: dec_wd = vx_reg ^ vy_reg;
                    4'h4: begin
                        dec_wd = add9[7:0];
                        dec_vf = add9[8];
                        dec_st = ST_WVF;
                    end
                    4'h5: begin
                        dec_wd = sub_xy[7:0];
                        dec_vf = vy_reg <= vx_reg;
                        dec_st = ST_WVF;
                    end
                    4'h6: begin
                        dec_wd = {1'b0, vx_reg[7:1]};
                        dec_vf = vx_reg[0];
                        dec_st = ST_WVF;
                    end
                    4'h7: begin
                        dec_wd = sub_yx[7:0];
                        dec_vf = vx_reg <= vy_reg;
                        dec_st = ST_WVF;
                    end
                    4'hE: begin
                        dec_wd = {vx_reg[6:0], 1'b0};
                        dec_vf = vx_reg[7];
                        dec_st = ST_WVF;
                    end
                    default: begin
                        dec_we  = 1'b0;
                        dec_bad = 1'b1;
                    end
                endcase
            end
            4'h9: begin
                if (op_n != 4'h0) dec_bad = 1'b1;
                else if (vx_reg != vy_reg) dec_pc = pc_reg + 12'd4;
            end
            4'hA: ;
            4'hB: dec_pc = op_nnn + {4'b0, v0_reg};
            4'hC: begin
                dec_we = 1'b1;
                dec_wd = rnd_reg & op_nn;
            end
            4'hD: dec_st = ST_D0;
            4'hE: begin
                if (op_nn == NN_SKP) begin
                    if (keys_reg[vx_reg[3:0]]) dec_pc = pc_reg + 12'd4;
                end else if (op_nn == NN_SKNP) begin
                    if (!keys_reg[vx_reg[3:0]]) dec_pc = pc_reg + 12'd4;
                end else begin
                    dec_bad = 1'b1;
                end
            end
            4'hF: begin
                unique case (op_nn)
                    NN_GETDLY: begin
                        dec_we = 1'b1;
                        dec_wd = delay_reg;
                    end
                    NN_WAITKEY: begin
                        if (key_any) begin
                            dec_we = 1'b1;
                            dec_wd = {4'b0, key_first};
                        end else begin
                            dec_wait = 1'b1;
                            dec_pc   = pc_reg;
                        end
                    end
                    NN_SETDLY, NN_SETSND, NN_FONT: ;
                    NN_ADDI: begin
                        dec_vf = |isum[16:12];
                        dec_st = ST_WVF;
                    end
                    NN_BCD:   dec_st = ST_BCD;
                    NN_STORE: dec_st = ST_S55A;
                    NN_LOAD:  dec_st = ST_S65A;
                    default:  dec_bad = 1'b1;
                endcase
            end
        endcase
        if (dec_bad) begin
            dec_pc = pc_reg;
            dec_st = ST_TICK;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: if (clr_reg == '1) state_next = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    unique case (cmd_t'(s_tuser))
                        CMD_LOAD:  state_next = ST_WM;
                        CMD_EXEC:  state_next = ST_F0;
                        CMD_RDMEM: state_next = ST_RM;
                        CMD_RDPIX: state_next = ST_RP;
                        default:   state_next = ST_OUT;
                    endcase
                end
            end
            ST_WM:   state_next = ST_OUT;
            ST_RM:   state_next = ST_RM2;
            ST_RM2:  state_next = ST_OUT;
            ST_RP:   state_next = ST_RP2;
            ST_RP2:  state_next = ST_OUT;
            ST_F0:   state_next = ST_F1;
            ST_F1:   state_next = ST_F2;
            ST_F2:   state_next = ST_F3;
            ST_F3:   state_next = ST_F4;
            ST_F4:   state_next = ST_F5;
            ST_F5:   state_next = ST_EXEC;
            ST_EXEC: state_next = dec_st;
            ST_WVF:  state_next = ST_TICK;
            ST_D0:   state_next = (cnt_reg == {1'b0, op_n}) ? ST_WVF : ST_D1;
            ST_D1:   state_next = ST_D0;
            ST_BCD:  if (cnt_reg == 5'd2) state_next = ST_TICK;
            ST_S55A: state_next = (cnt_reg == {1'b0, op_x} + 5'd1) ? ST_TICK : ST_S55B;
            ST_S55B: state_next = ST_S55A;
            ST_S65A: state_next = (cnt_reg == {1'b0, op_x} + 5'd1) ? ST_TICK : ST_S65B;
            ST_S65B: state_next = ST_S65A;
            ST_TICK: state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Store port control per state.
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = idx_cnt;
        mem_wdata = 8'h00;
        mem_raddr = pc_reg;
        rf_we     = 1'b0;
        rf_waddr  = op_x;
        rf_wdata  = dec_wd;
        rf_raddr  = op_x;
        bm_we     = 1'b0;
        bm_waddr  = row_cnt;
        bm_wdata  = bm_q ^ mask;
        bm_raddr  = row_cnt;
        unique case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = font_at(clr_reg);
            end
            ST_IDLE: s_tready = 1'b1;
            ST_WM: begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = data_reg;
            end
            ST_RM:   mem_raddr = addr_reg;
            ST_RP:   bm_raddr = addr_reg[ROW_AW+COL_AW-1:COL_AW];
            ST_F1:   mem_raddr = pc_reg + 12'd1;
            ST_F2:   rf_raddr = op_x;
            ST_F3:   rf_raddr = op_y;
            ST_F4:   rf_raddr = 4'd0;
            ST_EXEC: rf_we = dec_we;
            ST_WVF: begin
                rf_we    = 1'b1;
                rf_waddr = 4'hF;
                rf_wdata = {7'b0, vf_reg};
            end
            ST_D0:   mem_raddr = idx_cnt;
            ST_D1:   bm_we = 1'b1;
            ST_BCD: begin
                mem_we = 1'b1;
                if (cnt_reg[1:0] == 2'd0) mem_wdata = {4'b0, dig2_reg};
                else if (cnt_reg[1:0] == 2'd1) mem_wdata = {4'b0, dig1_reg};
                else mem_wdata = {4'b0, dig0_reg};
            end
            ST_S55A: rf_raddr = cnt_reg[3:0];
            ST_S55B: begin
                mem_we    = 1'b1;
                mem_wdata = rf_q;
            end
            ST_S65A: mem_raddr = idx_cnt;
            ST_S65B: begin
                rf_we    = 1'b1;
                rf_waddr = cnt_reg[3:0];
                rf_wdata = mem_q;
            end
            default: ;
        endcase
    end

    // Sequencer, architectural state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            clr_reg      <= '0;
            pc_reg       <= 12'(PROGRAM_BASE);
            idx_reg      <= 16'h0000;
            sp_reg       <= '0;
            for (int i = 0; i < STACK_DEPTH; i++) stack_reg[i] <= 12'h000;
            delay_reg    <= 8'h00;
            sound_reg    <= 8'h00;
            keys_reg     <= 16'h0000;
            rf_valid_reg <= 16'h0000;
            bm_valid_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) clr_reg <= clr_reg + MEM_AW'(1);
            if (rf_we) rf_valid_reg[rf_waddr] <= 1'b1;
            if (bm_we) bm_valid_reg[bm_waddr] <= 1'b1;
            if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (accept && cmd_t'(s_tuser) == CMD_KEY) keys_reg[s_tdata[23:20]] <= s_tdata[24];

            unique case (state_reg)
                ST_EXEC: begin
                    pc_reg <= dec_pc;
                    if (!dec_bad) begin
                        unique case (op_nib)
                            4'h0: begin
                                if (op == OP_CLS) bm_valid_reg <= '0;
                                else sp_reg <= sp_dec;
                            end
                            4'h2: begin
                                stack_reg[sp_reg] <= pc_reg;
                                sp_reg <= sp_inc;
                            end
                            4'hA: idx_reg <= {4'b0, op_nnn};
                            4'hF: begin
                                if (op_nn == NN_SETDLY) delay_reg <= vx_reg;
                                if (op_nn == NN_SETSND) sound_reg <= vx_reg;
                                if (op_nn == NN_ADDI) idx_reg <= isum[15:0];
                                if (op_nn == NN_FONT) begin
                                    idx_reg <= 16'({4'b0, vx_reg[3:0]} * 8'd5);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_S55A, ST_S65A: begin
                    if (cnt_reg == {1'b0, op_x} + 5'd1) begin
                        idx_reg <= idx_reg + {11'b0, cnt_reg};
                    end
                end
                ST_TICK: begin
                    if (delay_reg != 8'h00) delay_reg <= delay_reg - 8'd1;
                    if (sound_reg != 8'h00) sound_reg <= sound_reg - 8'd1;
                end
                default: ;
            endcase
        end
    end

    // Item payload and working registers.
    always_ff @(posedge aclk) begin
        rf_rv_reg <= rf_valid_reg[rf_raddr];
        bm_rv_reg <= bm_valid_reg[bm_raddr];
        if (accept) begin
            addr_reg <= s_tdata[11:0];
            data_reg <= s_tdata[19:12];
            rnd_reg  <= s_tdata[32:25];
            hi_reg   <= 8'h00;
            lo_reg   <= 8'h00;
            rd_reg   <= 8'h00;
            drew_reg <= 1'b0;
            bad_reg  <= 1'b0;
            wait_reg <= 1'b0;
        end
        unique case (state_reg)
            ST_RM2: rd_reg <= mem_q;
            ST_RP2: rd_reg <= {7'b0, bm_q[addr_reg[COL_AW-1:0]]};
            ST_F1:  hi_reg <= mem_q;
            ST_F2:  lo_reg <= mem_q;
            ST_F3:  vx_reg <= rf_q;
            ST_F4:  vy_reg <= rf_q;
            ST_F5:  v0_reg <= rf_q;
            ST_EXEC: begin
                bad_reg  <= dec_bad;
                wait_reg <= dec_wait;
                vf_reg   <= dec_vf;
                cnt_reg  <= 5'd0;
                coll_reg <= 1'b0;
                if (op == OP_CLS) drew_reg <= 1'b1;
                dig2_reg <= {2'b0, bcd_h};
                dig1_reg <= bcd_t;
                dig0_reg <= bcd_o[3:0];
            end
            ST_D0: begin
                if (cnt_reg == {1'b0, op_n}) begin
                    vf_reg   <= coll_reg;
                    drew_reg <= 1'b1;
                end
            end
            ST_D1: begin
                coll_reg <= coll_reg | (|(bm_q & mask));
                cnt_reg  <= cnt_reg + 5'd1;
            end
            ST_BCD, ST_S55B, ST_S65B: cnt_reg <= cnt_reg + 5'd1;
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {wait_reg, bad_reg, sound_reg != 8'h00, drew_reg,
                                   rd_reg, op, pc_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Main memory, 4096 bytes.
    spvm_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    // General registers V0 to VF.
    spvm_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
        .aclk  (aclk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    // Frame bitmap, one row per entry.
    spvm_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_bitmap (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

endmodule

/* sv/spvm_checker.sv */
// Port-level checks on the sprite machine core, bound to its top level.
module spvm_checker import spvm_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A result held back by the receiver stays unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result is offered right after reset.
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // The core works on one item at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // An unrecognized word neither draws nor waits for a key.
    a_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[38] |-> !m_tdata[39] && !m_tdata[36])
        else $error("bad opcode with other status");

    // Read values and executed words never appear together.
    a_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[35:28] != 8'h00 |-> m_tdata[27:12] == 16'h0000)
        else $error("read value on an execute result");

endmodule

bind sprite_vm_cpu_core spvm_checker u_spvm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
